/* src/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication checked at every clock edge out of reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/raec_pkg.sv */
// Shared constants, types and codes for the readout aggregate event counter.
package raec_pkg;

  localparam int CHANNEL_PAIRS_DEF = 8;

  localparam int WORD_W       = 32;
  localparam int LEN_W        = 24;
  localparam int BOARD_SIZE_W = 28;
  localparam int SIZE_W       = 22;
  localparam int SAMPLES_W    = 16;
  localparam int EV_W         = 18;
  localparam int COUNT_W      = 32;
  localparam int STATUS_W     = 3;

  localparam logic [3:0] BOARD_TAG = 4'hA;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_BOARD  = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_BAD_CHAN   = 3'd3,
    ST_BAD_FORMAT = 3'd4,
    ST_IN_CHAN    = 3'd5
  } status_t;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_BOARD   = 8'b0000_0001,
    PH_MASK    = 8'b0000_0010,
    PH_SKIP_A  = 8'b0000_0100,
    PH_SKIP_B  = 8'b0000_1000,
    PH_CHAN    = 8'b0001_0000,
    PH_FORMAT  = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_STOP    = 8'b1000_0000
  } phase_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [EV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SIZE_W-1:0] quotient;
  } div_rsp_t;

  // One result transaction
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_t            status;
  } res_t;

endpackage

/* src/raec_div.sv */
// Iterative restoring divider: one quotient bit per cycle.
`include "assert_macros.svh"

module raec_div (
  input  logic              clk,
  input  logic              rst_n,
  input  raec_pkg::div_req_t req,
  output raec_pkg::div_rsp_t rsp
);
  import raec_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [EV_W-1:0]   rem_r;
  logic [SIZE_W-1:0] quo_r;
  logic [EV_W-1:0]   dsr_r;

  logic [EV_W:0]     rem_sh;
  logic [EV_W:0]     diff;
  logic              fits;

  // Shift in next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[SIZE_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    fits   = !diff[EV_W];
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SIZE_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[EV_W-1:0] : rem_sh[EV_W-1:0];
      quo_r <= {quo_r[SIZE_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `ASSERT_IMPLIES(a_no_restart, req.start, !busy_r && !done_r, "divider restarted while active")
  `ASSERT_IMPLIES(a_done_after_busy, done_r, !busy_r && $past(busy_r), "done without a run")

endmodule

/* src/raec_parser.sv */
// Buffer parser: walks board and channel aggregates and accumulates the count.
`include "assert_macros.svh"

module raec_parser #(
  parameter int CHANNEL_PAIRS = raec_pkg::CHANNEL_PAIRS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [raec_pkg::WORD_W-1:0]  in_data_word,
  input  logic                         in_first_word,
  input  logic [raec_pkg::LEN_W-1:0]   in_buffer_words,
  output logic                         res_valid,
  output raec_pkg::res_t               res,
  input  logic                         res_take
);
  import raec_pkg::*;

  localparam int NP  = CHANNEL_PAIRS;
  localparam int PIW = (NP > 1) ? $clog2(NP) : 1;
  localparam int SW  = PIW + 1;

  logic [LEN_W-1:0]   word_pos_r,  word_pos_nxt;
  logic [LEN_W-1:0]   buf_len_r,   buf_len_nxt;
  phase_t             phase_r,     phase_nxt;
  logic [PIW-1:0]     pair_idx_r,  pair_idx_nxt;
  logic [NP-1:0]      pair_mask_r, pair_mask_nxt;
  logic [SIZE_W-1:0]  skip_r,      skip_nxt;
  logic [SIZE_W-1:0]  chan_size_r, chan_size_nxt;
  logic [COUNT_W-1:0] count_r,     count_nxt;
  status_t            err_r,       err_nxt;
  logic               emit_pend_r, emit_pend_nxt;
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r,       res_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               accept;
  logic               active;
  logic               last;
  logic [SW-1:0]      found;
  logic [SIZE_W-1:0]  rest;

  // First enabled pair at or above start; top bit flags a hit
  function automatic logic [SW-1:0] seek(input logic [NP-1:0] mask,
                                         input logic [SW-1:0] start);
    logic          hit;
    logic [PIW-1:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < NP; i++) begin
      if (!hit && mask[i] && (SW'(i) >= start)) begin
        hit = 1'b1;
        idx = PIW'(i);
      end
    end
    return {hit, idx};
  endfunction

  // Status as seen at the end of a buffer
  function automatic status_t status_of(input status_t err, input phase_t ph);
    status_t st;
    if (err != ST_OK) begin
      st = err;
    end else begin
      case (ph)
        PH_BOARD:                     st = ST_OK;
        PH_MASK, PH_SKIP_A, PH_SKIP_B: st = ST_TRUNCATED;
        default:                      st = ST_IN_CHAN;
      endcase
    end
    return st;
  endfunction

  assign in_stall = div_rsp.busy || div_rsp.done || res_valid_r;
  assign accept   = in_valid && !in_stall;

  // Next-state logic for one word transaction
  always_comb begin
    word_pos_nxt  = word_pos_r;
    buf_len_nxt   = buf_len_r;
    phase_nxt     = phase_r;
    pair_idx_nxt  = pair_idx_r;
    pair_mask_nxt = pair_mask_r;
    skip_nxt      = skip_r;
    chan_size_nxt = chan_size_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    emit_pend_nxt = emit_pend_r;
    res_valid_nxt = res_valid_r && !res_take;
    res_nxt       = res_r;
    div_req.start    = 1'b0;
    div_req.dividend = chan_size_r - SIZE_W'(2);
    div_req.divisor  = {in_data_word[SAMPLES_W-1:0], 2'b00} + EV_W'(2)
                       + EV_W'(in_data_word[28]);
    active = 1'b0;
    last   = 1'b0;
    found  = '0;
    rest   = '0;

    // Quotient of the last format word arrives
    if (div_rsp.done) begin
      count_nxt = count_r + COUNT_W'(div_rsp.quotient);
      if (emit_pend_r) begin
        emit_pend_nxt  = 1'b0;
        res_valid_nxt  = 1'b1;
        res_nxt.count  = count_nxt;
        res_nxt.status = status_of(err_r, phase_r);
      end
    end

    if (accept) begin
      if (in_first_word) begin
        word_pos_nxt  = '0;
        buf_len_nxt   = (in_buffer_words == '0) ? LEN_W'(1) : in_buffer_words;
        phase_nxt     = PH_BOARD;
        pair_idx_nxt  = '0;
        pair_mask_nxt = '0;
        skip_nxt      = '0;
        chan_size_nxt = '0;
        count_nxt     = '0;
        err_nxt       = ST_OK;
        active        = 1'b1;
      end else begin
        active = word_pos_r < buf_len_r;
      end

      if (active) begin
        case (phase_nxt)
          PH_BOARD: begin
            if (in_data_word[31:28] != BOARD_TAG) begin
              err_nxt   = ST_BAD_BOARD;
              phase_nxt = PH_STOP;
            end else if (in_data_word[BOARD_SIZE_W-1:0] >
                         BOARD_SIZE_W'(buf_len_nxt - word_pos_nxt)) begin
              err_nxt   = ST_TRUNCATED;
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_MASK;
            end
          end
          PH_MASK: begin
            pair_mask_nxt = in_data_word[NP-1:0];
            phase_nxt     = PH_SKIP_A;
          end
          PH_SKIP_A: phase_nxt = PH_SKIP_B;
          PH_SKIP_B: begin
            found        = seek(pair_mask_nxt, '0);
            pair_idx_nxt = found[SW-1] ? found[PIW-1:0] : pair_idx_nxt;
            phase_nxt    = found[SW-1] ? PH_CHAN : PH_BOARD;
          end
          PH_CHAN: begin
            if (!in_data_word[31]) begin
              err_nxt   = ST_BAD_CHAN;
              phase_nxt = PH_STOP;
            end else begin
              chan_size_nxt = in_data_word[SIZE_W-1:0];
              if (in_data_word[SIZE_W-1:1] == '0) begin
                err_nxt   = ST_BAD_FORMAT;
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_FORMAT;
              end
            end
          end
          PH_FORMAT: begin
            if (in_data_word[30:29] != 2'b11) begin
              err_nxt   = ST_BAD_FORMAT;
              phase_nxt = PH_STOP;
            end else begin
              div_req.start = 1'b1;
              rest          = chan_size_nxt - SIZE_W'(2);
              skip_nxt      = rest;
              if (rest == '0) begin
                found        = seek(pair_mask_nxt, SW'(pair_idx_nxt) + SW'(1));
                pair_idx_nxt = found[SW-1] ? found[PIW-1:0] : pair_idx_nxt;
                phase_nxt    = found[SW-1] ? PH_CHAN : PH_BOARD;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            skip_nxt = skip_nxt - SIZE_W'(1);
            if (skip_nxt == '0) begin
              found        = seek(pair_mask_nxt, SW'(pair_idx_nxt) + SW'(1));
              pair_idx_nxt = found[SW-1] ? found[PIW-1:0] : pair_idx_nxt;
              phase_nxt    = found[SW-1] ? PH_CHAN : PH_BOARD;
            end
          end
          default: ;
        endcase

        // End of buffer: result now, or once the quotient is in
        last         = ({1'b0, word_pos_nxt} + (LEN_W+1)'(1)) >= {1'b0, buf_len_nxt};
        word_pos_nxt = word_pos_nxt + LEN_W'(1);
        if (last) begin
          if (div_req.start) begin
            emit_pend_nxt = 1'b1;
          end else begin
            res_valid_nxt  = 1'b1;
            res_nxt.count  = count_nxt;
            res_nxt.status = status_of(err_nxt, phase_nxt);
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_pos_r  <= '0;
      buf_len_r   <= '0;
      phase_r     <= PH_BOARD;
      pair_idx_r  <= '0;
      pair_mask_r <= '0;
      skip_r      <= '0;
      chan_size_r <= '0;
      count_r     <= '0;
      err_r       <= ST_OK;
      emit_pend_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      word_pos_r  <= word_pos_nxt;
      buf_len_r   <= buf_len_nxt;
      phase_r     <= phase_nxt;
      pair_idx_r  <= pair_idx_nxt;
      pair_mask_r <= pair_mask_nxt;
      skip_r      <= skip_nxt;
      chan_size_r <= chan_size_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      emit_pend_r <= emit_pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  raec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `ASSERT_IMPLIES(a_res_not_during_div, res_valid_r, !div_rsp.busy, "result pending while dividing")
  `ASSERT_IMPLIES(a_pend_has_div, emit_pend_r, div_rsp.busy || div_rsp.done, "pending result lost its divide")

endmodule

/* src/readout_aggregate_event_counter_core.sv */
// Top level of the readout aggregate event counter with its output register.
//
// Input channel (in_valid / in_stall): one 32-bit buffer word per transaction,
// with in_first_word marking the first word of a buffer and in_buffer_words
// its length, sampled on that first word.
// Output channel (out_valid / out_stall): one transaction per buffer whose last
// word arrives, carrying the event count and parse status.
// Throughput: one word per cycle for all words but channel format words, unless the
// output stalls; the word after a buffer's last word waits while the result moves out.
// A format word starts the shared restoring divider (one quotient bit per
// cycle over 22 bits) and holds the input until the quotient is in.
// The result passes the parser's result register and then the output register
// before it is on out_valid, after the quotient when the last word is a format word.
// A finished result waits in a parser stage while the output register is
// stalled; the input stalls while that stage is occupied.
// Reset (rst_n low, synchronous) clears all parse state; words that arrive
// outside a buffer are taken and dropped.
module readout_aggregate_event_counter_core #(
  parameter int CHANNEL_PAIRS = raec_pkg::CHANNEL_PAIRS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [raec_pkg::WORD_W-1:0]    in_data_word,
  input  logic                           in_first_word,
  input  logic [raec_pkg::LEN_W-1:0]     in_buffer_words,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [raec_pkg::COUNT_W-1:0]   out_event_count,
  output logic [raec_pkg::STATUS_W-1:0]  out_parse_status
);
  import raec_pkg::*;

  logic res_valid;
  res_t res;
  logic res_take;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  raec_parser #(
    .CHANNEL_PAIRS (CHANNEL_PAIRS)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_first_word   (in_first_word),
    .in_buffer_words (in_buffer_words),
    .res_valid       (res_valid),
    .res             (res),
    .res_take        (res_take)
  );

  // Output register takes a result when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_count  = out_res_r.count;
  assign out_parse_status = out_res_r.status;

endmodule

/* tb/raec_tally_checker.sv */
`timescale 1ns / 100ps
// Checker for the event counter: predicts per-buffer tallies and compares results.
module raec_tally_checker #(
  parameter int CHANNEL_PAIRS = raec_pkg::CHANNEL_PAIRS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [raec_pkg::WORD_W-1:0]    in_data_word,
  input  logic                           in_first_word,
  input  logic [raec_pkg::LEN_W-1:0]     in_buffer_words,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [raec_pkg::COUNT_W-1:0]   out_event_count,
  input  logic [raec_pkg::STATUS_W-1:0]  out_parse_status,
  output int                             fail_count,
  output int                             pending
);
  import raec_pkg::*;

  // Parser state of the prediction
  logic [LEN_W-1:0]   word_pos;
  logic [LEN_W-1:0]   buf_len;
  phase_t             phase;
  logic [2:0]         pair_idx;
  logic [7:0]         pair_mask;
  logic [SIZE_W-1:0]  skip_left;
  logic [SIZE_W-1:0]  chan_size;
  logic [COUNT_W-1:0] running;
  status_t            err;

  // Expected tallies, oldest first
  res_t tally_q[$];
  res_t want;
  res_t fresh;
  logic has_tally;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, exp_val, got_val);
    fail_count++;
  endtask

  task automatic reset_parse();
    phase = PH_BOARD;
    pair_idx = '0;
    pair_mask = '0;
    skip_left = '0;
    chan_size = '0;
    running = '0;
    err = ST_OK;
  endtask

  task automatic abort_parse(input status_t code);
    err = code;
    phase = PH_STOP;
  endtask

  // Next enabled pair at or above start, else back to a board header
  task automatic find_pair(input int start);
    logic hit;
    hit = 1'b0;
    for (int i = start; i < 8; i++) begin
      if (!hit && i < CHANNEL_PAIRS && pair_mask[i]) begin
        hit = 1'b1;
        pair_idx = i[2:0];
        phase = PH_CHAN;
      end
    end
    if (!hit) phase = PH_BOARD;
  endtask

  // Advance the parser by one word; a tally comes out on the last word of a buffer
  task automatic parse_word(input logic [WORD_W-1:0] w, input logic first,
                            input logic [LEN_W-1:0] n, output logic has_res,
                            output res_t res);
    logic [31:0] ev;
    logic        last;
    has_res = 1'b0;
    res = '0;
    if (first) begin
      word_pos = '0;
      buf_len = (n == '0) ? 24'd1 : n;
      reset_parse();
    end else if (word_pos >= buf_len) begin
      return;
    end

    case (phase)
      PH_BOARD: begin
        if (w[31:28] != BOARD_TAG) begin
          abort_parse(ST_BAD_BOARD);
        end else if ({4'b0, w[27:0]} > ({8'b0, buf_len} - {8'b0, word_pos})) begin
          abort_parse(ST_TRUNCATED);
        end else begin
          phase = PH_MASK;
        end
      end
      PH_MASK: begin
        pair_mask = w[7:0];
        phase = PH_SKIP_A;
      end
      PH_SKIP_A: phase = PH_SKIP_B;
      PH_SKIP_B: find_pair(0);
      PH_CHAN: begin
        if (!w[31]) begin
          abort_parse(ST_BAD_CHAN);
        end else begin
          chan_size = w[SIZE_W-1:0];
          if (chan_size < 2) abort_parse(ST_BAD_FORMAT);
          else phase = PH_FORMAT;
        end
      end
      PH_FORMAT: begin
        if (w[30:29] != 2'b11) begin
          abort_parse(ST_BAD_FORMAT);
        end else begin
          ev = 4 * w[15:0] + 2 + w[28];
          running = running + (({10'b0, chan_size} - 32'd2) / ev);
          skip_left = chan_size - SIZE_W'(2);
          if (skip_left == '0) find_pair(int'(pair_idx) + 1);
          else phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        skip_left = skip_left - SIZE_W'(1);
        if (skip_left == '0) find_pair(int'(pair_idx) + 1);
      end
      default: ;
    endcase

    last = ({8'b0, word_pos} + 32'd1) >= {8'b0, buf_len};
    word_pos = word_pos + LEN_W'(1);
    if (last) begin
      has_res = 1'b1;
      res.count = running;
      if (err != ST_OK) res.status = err;
      else if (phase == PH_BOARD) res.status = ST_OK;
      else if (phase == PH_MASK || phase == PH_SKIP_A || phase == PH_SKIP_B)
        res.status = ST_TRUNCATED;
      else res.status = ST_IN_CHAN;
    end
  endtask

  // Results are checked before new words are predicted; no word yields a same-cycle result
  always @(posedge clk) begin
    if (!rst_n) begin
      word_pos = '0;
      buf_len = '0;
      reset_parse();
      tally_q.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tally_q.size() == 0) begin
          report_mismatch("result transaction with nothing pending, count", 32'd0,
                          out_event_count);
        end else begin
          want = tally_q.pop_front();
          if (out_event_count !== want.count)
            report_mismatch("event count", want.count, out_event_count);
          if (out_parse_status !== want.status)
            report_mismatch("parse status", {29'b0, want.status}, {29'b0, out_parse_status});
        end
      end
      if (in_valid && !in_stall) begin
        parse_word(in_data_word, in_first_word, in_buffer_words, has_tally, fresh);
        if (has_tally) tally_q.push_back(fresh);
      end
      pending = tally_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, readout buffer stimulus and verdict for the event counter.
module tb;
  import raec_pkg::*;

  localparam int ITEMS       = 850;
  localparam int MIN_BUFFERS = 10;
  localparam int CALM_WORDS  = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_WORDS  = 30;
  localparam int LIMIT       = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [WORD_W-1:0]  in_data_word;
  logic               in_first_word;
  logic [LEN_W-1:0]   in_buffer_words;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] out_event_count;
  logic [STATUS_W-1:0] out_parse_status;

  int  fail_count;
  int  pending;
  int  cycles;
  int  words_sent;
  int  buf_idx;
  bit  calm;
  bit  quiet_tx;
  bit  hold_req;
  logic [31:0] frame_q[$];

  readout_aggregate_event_counter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .in_first_word    (in_first_word),
    .in_buffer_words  (in_buffer_words),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_count  (out_event_count),
    .out_parse_status (out_parse_status)
  );

  raec_tally_checker tally_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .in_first_word    (in_first_word),
    .in_buffer_words  (in_buffer_words),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_count  (out_event_count),
    .out_parse_status (out_parse_status),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offer one word and hold it until the transaction completes
  task automatic send_word(input logic [31:0] d, input logic f, input logic [23:0] n);
    int gap;
    gap = 0;
    if (!calm && !quiet_tx && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_word <= d;
    in_first_word <= f;
    in_buffer_words <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering until every pending tally has come out
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Append one board aggregate with random content; its size word is now and then random
  task automatic add_board();
    int          base;
    int          ev;
    int          nev;
    logic [7:0]  mask;
    logic [15:0] smp;
    logic [21:0] csz;
    logic [27:0] bsize;
    logic [31:0] r;
    logic [31:0] r2;
    logic        extra;
    base = frame_q.size();
    frame_q.push_back(32'h0);
    r = $urandom;
    r2 = $urandom;
    case ($urandom_range(0, 5))
      0: mask = 8'h00;
      1: mask = 8'hFF;
      default: mask = r[7:0] & r2[7:0];
    endcase
    frame_q.push_back({r[31:8], mask});
    frame_q.push_back($urandom);
    frame_q.push_back($urandom);
    for (int p = 0; p < 8; p++) begin
      if (mask[p]) begin
        r = $urandom;
        r2 = $urandom;
        if ($urandom_range(0, 7) == 0) smp = r[15:0];
        else smp = 16'($urandom_range(0, 2));
        extra = r[16];
        ev = 4 * smp + 2 + extra;
        nev = $urandom_range(0, 3);
        if (nev * ev > 48) nev = 0;
        csz = 22'(2 + nev * ev);
        // partial trailing event now and then
        if ($urandom_range(0, 1) == 1)
          csz = csz + 22'($urandom_range(0, (ev > 20) ? 20 : ev - 1));
        frame_q.push_back({1'b1, r[31:23], csz});
        frame_q.push_back({r2[31], 2'b11, extra, r2[27:16], smp});
        repeat (csz - 2) frame_q.push_back($urandom);
      end
    end
    bsize = 28'(frame_q.size() - base);
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom;
      bsize = r[27:0];
    end
    frame_q[base] = {BOARD_TAG, bsize};
  endtask

  // One buffer: mostly well-formed boards, some noise, damage, truncation or abandonment
  task automatic send_random_buffer();
    int          kind;
    int          nsend;
    int          eff;
    int          idx;
    logic [23:0] blen;
    logic [31:0] rnd;
    bit          whole;
    frame_q.delete();
    kind = $urandom_range(0, 19);
    if (kind <= 1) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back($urandom);
    end else begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) add_board();
      if ($urandom_range(0, 9) == 0) begin
        rnd = $urandom;
        idx = $urandom_range(0, frame_q.size() - 1);
        frame_q[idx] = frame_q[idx] ^ (32'h1 << rnd[4:0]);
      end
      if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 3)) frame_q.push_back($urandom);
    end
    blen = 24'(frame_q.size());
    if ($urandom_range(0, 9) == 0) blen = 24'($urandom_range(1, frame_q.size()));
    if (kind == 1) begin
      rnd = $urandom;
      blen = rnd[23:0];
    end
    if (blen == 24'd1 && $urandom_range(0, 1) == 1) blen = '0;
    eff = (blen == '0) ? 1 : blen;
    whole = (eff <= frame_q.size());
    nsend = whole ? eff : frame_q.size();
    if (whole && nsend > 1 && $urandom_range(0, 14) == 0) begin
      nsend = $urandom_range(1, nsend - 1);
      whole = 1'b0;
    end
    for (int i = 0; i < nsend; i++) begin
      rnd = $urandom;
      send_word(frame_q[i], (i == 0), (i == 0) ? blen : rnd[23:0]);
    end
    words_sent += nsend;
    if (whole) begin
      // stray words between buffers are dropped by the block
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          rnd = $urandom;
          send_word($urandom, 1'b0, rnd[23:0]);
        end
      end
    end
  endtask

  // Result side: random stall bursts, quiet stretches, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [31:0] rnd;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_first_word = 1'b0;
    in_buffer_words = '0;
    calm = 1'b0;
    quiet_tx = 1'b0;
    hold_req = 1'b0;
    words_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stray word right after reset
    send_word(32'hFFFF_FFFF, 1'b0, 24'hFF_FFFF);
    // zero length acts as one word; bad board header
    send_word(32'h0000_0000, 1'b1, 24'd0);
    // header only: ends inside the board words
    send_word(32'hA000_0001, 1'b1, 24'd1);
    // board larger than the buffer, trailing word ignored
    send_word(32'hA000_0003, 1'b1, 24'd2);
    send_word(32'h5555_5555, 1'b0, 24'hAA_AAAA);
    // clean board, pair 0, one event
    send_word(32'hA000_0008, 1'b1, 24'd8);
    send_word(32'h0000_0001, 1'b0, 24'd0);
    send_word(32'hFFFF_FFFF, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    send_word(32'h8000_0004, 1'b0, 24'd0);
    send_word(32'h6000_0000, 1'b0, 24'd0);
    send_word(32'hFFFF_FFFF, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    // channel header without its top bit
    send_word(32'hA000_0005, 1'b1, 24'd5);
    send_word(32'h0000_00FF, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    send_word(32'h7FFF_FFFF, 1'b0, 24'd0);
    // maximum length buffer abandoned by a new one; then channel size below two
    send_word(32'hAFFF_FFFF, 1'b1, 24'hFF_FFFF);
    send_word(32'hA000_0006, 1'b1, 24'd6);
    send_word(32'h0000_0080, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    send_word(32'h0000_0000, 1'b0, 24'd0);
    send_word(32'h8000_0001, 1'b0, 24'd0);
    send_word(32'h7000_FFFF, 1'b0, 24'd0);
    wait_results();

    buf_idx = 0;
    while (words_sent < ITEMS || buf_idx < MIN_BUFFERS) begin
      calm = (words_sent >= ITEMS - CALM_WORDS);
      quiet_tx = ($urandom_range(0, 3) == 0);
      if (buf_idx == 8) begin
        // long hold-off on results while one-word buffers keep coming
        hold_req = 1'b1;
        repeat (HOLD_WORDS) begin
          rnd = $urandom;
          send_word(rnd, 1'b1, 24'd1);
        end
        words_sent += HOLD_WORDS;
      end else if (buf_idx == 3 || buf_idx == 6) begin
        wait_results();
      end
      send_random_buffer();
      buf_idx++;
    end

    wait_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
